/* rtl/core/dlpd_pkg.sv */
package dlpd_pkg;

   // Table depth and derived widths
   localparam int MAX_ENTRIES = 1024;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 11;
   localparam int STATUS_W    = 3;

   // Transaction kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FORMAT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DUP    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd5;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [STATUS_W-1:0]       status;
      logic [COUNT_W-1:0]        count;
      logic                      last;
   } rsp_type;

   // Lookup probe that walks the cell row
   typedef struct packed {
      logic               valid;
      logic               hit;
      logic [COUNT_W-1:0] remain;
   } probe_type;

endpackage

/* rtl/core/decimal_list_parser_with_dedup_core.sv */
// Decimal list parser with duplicate check.
// req channel: one transaction per character (kind = char) or an end-of-list
// marker (kind = end). Spaces separate tokens; each token is an optional sign
// followed by decimal digits and must fit a signed 32-bit integer.
// rsp channel: one transaction per closed token (value with ok, or an error),
// and a summary with last = 1 for each end-of-list marker.
// A character that does not close a token only updates the token state, and
// one character per cycle is accepted while the output register is free. A
// closing token launches a probe through the row of MAX_ENTRIES storage cells,
// one cell per cycle; its result passes the launch register, the cells and the
// output register, and no input is taken meanwhile. A lone sign or an out of
// range token skips the probe; its error goes straight to the output register.
// An end-of-list marker that closes a token sends the summary after its result.
// After the first error, characters are dropped until the end-of-list marker.
// Reset clears the list, the count and the error; table contents are not
// cleared, only entries below the count are compared.
// A result waits in the output register while rsp_ready is low; a new
// request is taken only when that register is free or being emptied.
module decimal_list_parser_with_dedup_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dlpd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dlpd_pkg::rsp_type rsp_data
);
   import dlpd_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_SUMMARY} state_type;
   typedef enum logic [1:0] {PH_IDLE, PH_SIGN, PH_DIGITS} phase_type;

   localparam logic [7:0]  CH_SPACE  = 8'h20;
   localparam logic [7:0]  CH_PLUS   = 8'h2B;
   localparam logic [7:0]  CH_MINUS  = 8'h2D;
   localparam logic [7:0]  CH_ZERO   = 8'h30;
   localparam logic [7:0]  CH_NINE   = 8'h39;
   localparam logic [35:0] MAG_LIMIT = 36'h080000000;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic               ovf_ff, ovf_in;
   logic               neg_ff, neg_in;
   logic [STATUS_W-1:0] err_ff, err_in;
   logic               seen_ff, seen_in;
   logic               eol_ff, eol_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic               launch_ff, launch_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               out_free;
   logic               shift_en;
   probe_type          probe_first;
   probe_type          probe_last;
   logic [35:0]        mag_next;
   logic [VALUE_W-1:0] close_val;
   logic               close_fmt;
   logic               close_rng;

   // Storage row
   dlpd_chain u_chain (
      .clock       (clock),
      .reset       (reset),
      .shift_en    (shift_en),
      .key         (key_ff),
      .probe_first (probe_first),
      .probe_last  (probe_last)
   );

   assign probe_first.valid  = launch_ff;
   assign probe_first.hit    = 1'b0;
   assign probe_first.remain = count_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Token arithmetic
   assign mag_next  = ({4'd0, mag_ff} << 3) + ({4'd0, mag_ff} << 1)
                      + {32'd0, req_data.char_code[3:0]};
   assign close_val = neg_ff ? (VALUE_W'(0) - mag_ff) : mag_ff;
   assign close_fmt = (phase_ff == PH_SIGN);
   assign close_rng = ovf_ff || (!neg_ff && mag_ff[VALUE_W-1]);

   // Next-state logic
   always_comb begin
      logic                do_close;
      logic                raise;
      logic [STATUS_W-1:0] raise_code;
      logic                do_summary;
      logic [STATUS_W-1:0] sum_status;

      do_close     = 1'b0;
      raise        = 1'b0;
      raise_code   = ST_OK;
      do_summary   = 1'b0;
      sum_status   = err_ff;
      shift_en     = 1'b0;

      state_in     = state_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      mag_in       = mag_ff;
      ovf_in       = ovf_ff;
      neg_in       = neg_ff;
      err_in       = err_ff;
      seen_in      = seen_ff;
      eol_in       = eol_ff;
      key_in       = key_ff;
      launch_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_data.kind == KIND_END) begin
                  if ((err_ff == ST_OK) && seen_ff && (phase_ff != PH_IDLE)) begin
                     do_close = 1'b1;
                     eol_in   = 1'b1;
                  end else begin
                     do_summary = 1'b1;
                     sum_status = ((err_ff == ST_OK) && !seen_ff) ? ST_EMPTY : err_ff;
                  end
               end else begin
                  seen_in = 1'b1;
                  if (err_ff != ST_OK) begin
                     // drop characters after an error
                  end else if (req_data.char_code == CH_SPACE) begin
                     do_close = (phase_ff != PH_IDLE);
                  end else if ((req_data.char_code == CH_PLUS) ||
                               (req_data.char_code == CH_MINUS)) begin
                     if (phase_ff != PH_IDLE) begin
                        raise      = 1'b1;
                        raise_code = ST_FORMAT;
                     end else begin
                        neg_in   = (req_data.char_code == CH_MINUS);
                        phase_in = PH_SIGN;
                     end
                  end else if (req_data.char_code inside {[CH_ZERO:CH_NINE]}) begin
                     phase_in = PH_DIGITS;
                     if (ovf_ff || (mag_next > MAG_LIMIT)) begin
                        ovf_in = 1'b1;
                        mag_in = MAG_LIMIT[VALUE_W-1:0];
                     end else begin
                        mag_in = mag_next[VALUE_W-1:0];
                     end
                  end else begin
                     raise      = 1'b1;
                     raise_code = ST_FORMAT;
                  end
               end
            end
         end
         S_SEARCH: begin
            if (probe_last.valid) begin
               if (probe_last.hit) begin
                  raise      = 1'b1;
                  raise_code = ST_DUP;
               end else if (count_ff >= COUNT_W'(MAX_ENTRIES)) begin
                  raise      = 1'b1;
                  raise_code = ST_FULL;
               end else begin
                  shift_en           = 1'b1;
                  count_in           = count_ff + COUNT_W'(1);
                  phase_in           = PH_IDLE;
                  mag_in             = '0;
                  ovf_in             = 1'b0;
                  neg_in             = 1'b0;
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.value  = key_ff;
                  rsp_data_in.status = ST_OK;
                  rsp_data_in.count  = count_ff + COUNT_W'(1);
                  rsp_data_in.last   = 1'b0;
                  state_in           = eol_ff ? S_SUMMARY : S_IDLE;
               end
            end
         end
         S_SUMMARY: begin
            do_summary = out_free;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Close the open token: fast errors, or launch the table lookup
      if (do_close) begin
         if (close_fmt) begin
            raise      = 1'b1;
            raise_code = ST_FORMAT;
         end else if (close_rng) begin
            raise      = 1'b1;
            raise_code = ST_RANGE;
         end else begin
            key_in    = close_val;
            launch_in = 1'b1;
            state_in  = S_SEARCH;
         end
      end

      // Latch the first error and report it
      if (raise) begin
         err_in             = raise_code;
         phase_in           = PH_IDLE;
         mag_in             = '0;
         ovf_in             = 1'b0;
         neg_in             = 1'b0;
         rsp_valid_in       = 1'b1;
         rsp_data_in.value  = '0;
         rsp_data_in.status = raise_code;
         rsp_data_in.count  = count_ff;
         rsp_data_in.last   = 1'b0;
         state_in           = eol_in ? S_SUMMARY : S_IDLE;
      end

      // Report the list summary and start a fresh list
      if (do_summary) begin
         rsp_valid_in       = 1'b1;
         rsp_data_in.value  = '0;
         rsp_data_in.status = sum_status;
         rsp_data_in.count  = count_ff;
         rsp_data_in.last   = 1'b1;
         count_in           = '0;
         err_in             = ST_OK;
         seen_in            = 1'b0;
         eol_in             = 1'b0;
         phase_in           = PH_IDLE;
         mag_in             = '0;
         ovf_in             = 1'b0;
         neg_in             = 1'b0;
         state_in           = S_IDLE;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         mag_ff       <= '0;
         ovf_ff       <= 1'b0;
         neg_ff       <= 1'b0;
         err_ff       <= ST_OK;
         seen_ff      <= 1'b0;
         eol_ff       <= 1'b0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         mag_ff       <= mag_in;
         ovf_ff       <= ovf_in;
         neg_ff       <= neg_in;
         err_ff       <= err_in;
         seen_ff      <= seen_in;
         eol_ff       <= eol_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* rtl/core/dlpd_cell.sv */
module dlpd_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            shift_en,
   input  logic [dlpd_pkg::VALUE_W-1:0]    shift_in,
   output logic [dlpd_pkg::VALUE_W-1:0]    value_out,
   input  logic [dlpd_pkg::VALUE_W-1:0]    key,
   input  dlpd_pkg::probe_type             probe_in,
   output dlpd_pkg::probe_type             probe_out
);
   import dlpd_pkg::*;

   logic [VALUE_W-1:0] value_ff;
   probe_type          probe_ff;
   probe_type          probe_in_next;

   // Compare against the held entry while it is still inside the live prefix
   always_comb begin
      probe_in_next.valid  = probe_in.valid;
      probe_in_next.hit    = probe_in.hit
                             | ((probe_in.remain != '0) && (value_ff == key));
      probe_in_next.remain = (probe_in.remain != '0) ?
                             probe_in.remain - COUNT_W'(1) : '0;
   end

   // Shift stored entry toward the far end on insert
   always_ff @(posedge clock) begin
      if (shift_en) begin
         value_ff <= shift_in;
      end
   end

   // Advance the probe one cell per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff.valid <= probe_in_next.valid;
      end
      probe_ff.hit    <= probe_in_next.hit;
      probe_ff.remain <= probe_in_next.remain;
   end

   assign value_out = value_ff;
   assign probe_out = probe_ff;

endmodule

/* rtl/core/dlpd_chain.sv */
module dlpd_chain (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            shift_en,
   input  logic [dlpd_pkg::VALUE_W-1:0]    key,
   input  dlpd_pkg::probe_type             probe_first,
   output dlpd_pkg::probe_type             probe_last
);
   import dlpd_pkg::*;

   logic [VALUE_W-1:0] link_value [MAX_ENTRIES+1];
   probe_type          link_probe [MAX_ENTRIES+1];

   // New entries enter at the head; the probe enters at the head too
   assign link_value[0] = key;
   assign link_probe[0] = probe_first;

   // Row of storage cells
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      dlpd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .shift_in  (link_value[i]),
         .value_out (link_value[i+1]),
         .key       (key),
         .probe_in  (link_probe[i]),
         .probe_out (link_probe[i+1])
      );
   end

   assign probe_last = link_probe[MAX_ENTRIES];

endmodule

/* rtl/core/dlpd_check.sv */
module dlpd_check (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dlpd_pkg::rsp_type rsp_data
);
   import dlpd_pkg::*;

   // Hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Status codes stay within the defined set
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_OK) || (rsp_data.status == ST_FORMAT) ||
                    (rsp_data.status == ST_RANGE) || (rsp_data.status == ST_DUP) ||
                    (rsp_data.status == ST_EMPTY) || (rsp_data.status == ST_FULL))
      else $error("undefined status code");

   // Error and summary results carry a zero value
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.last || (rsp_data.status != ST_OK)) |->
         rsp_data.value == '0)
      else $error("nonzero value on error or summary");

   // Count never exceeds table depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.count <= COUNT_W'(MAX_ENTRIES))
      else $error("count beyond table depth");

   // Empty status appears only on a summary with no stored values
   a_empty_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_EMPTY) |->
         rsp_data.last && (rsp_data.count == '0))
      else $error("empty status outside an empty summary");

endmodule

bind decimal_list_parser_with_dedup_core dlpd_check u_dlpd_check (.*);
